// ===== rtl/core/sfrc_pkg.sv =====
// Shared types and constants for the serial frame receiver with checksum.
// Holds the controller state type, the status codes and the command and
// status structs between controller and datapath. No dependencies.
`default_nettype none

package sfrc_pkg;

    // Field widths fixed by the frame format.
    localparam int BYTE_W       = 8;
    localparam int COUNT_W      = 16;
    localparam int BYTE_COUNT_W = 7;
    localparam int MAXLEN_W     = 6;
    localparam int CFG_INDEX_W  = 2;

    // Frame layout: two headers, length, command, payload, checksum.
    localparam logic [BYTE_COUNT_W-1:0] POS_SECOND_HEADER = 7'd1;
    localparam logic [BYTE_COUNT_W-1:0] POS_LENGTH        = 7'd2;
    localparam logic [BYTE_COUNT_W-1:0] POS_COMMAND       = 7'd3;
    localparam logic [BYTE_COUNT_W-1:0] POS_PAYLOAD       = 7'd4;
    localparam logic [BYTE_COUNT_W-1:0] MIN_COMPLETE      = 7'd3;
    localparam logic [8:0]              FRAME_OVERHEAD    = 9'd5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD   = 2'd2;

    // Configuration reset values.
    localparam logic [BYTE_W-1:0]   RESET_HEADER_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0]   RESET_HEADER_SECOND = 8'h55;
    localparam logic [MAXLEN_W-1:0] RESET_MAX_PAYLOAD   = 6'd32;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_GOOD     = 2'd0,
        STAT_FORMAT   = 2'd1,
        STAT_CHECKSUM = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_HUNT,
        ST_RECV,
        ST_DRAIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    start;        // first header seen: clear frame fields
        logic    take;         // fold the accepted byte into the frame
        logic    emit;         // load a single status word into the output
        status_t emit_status;
        logic    inc_good;
        logic    inc_format;
        logic    inc_checksum;
        logic    drain_start;  // read payload entry zero
        logic    drain_load;   // move the read payload byte to the output
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;     // output register is empty or being taken
        logic start_match;  // incoming byte equals the first header
        logic buf_full;     // byte count reaches the buffer size
        logic complete;     // frame holds all its bytes
        logic len_over;     // length above the accepted maximum
        logic hdr_bad;      // second header mismatch
        logic sum_bad;      // checksum mismatch
        logic len_zero;     // empty payload
        logic drain_last;   // current drain byte is the final one
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/sfrc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the payload store. No dependencies.
`default_nettype none

module sfrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sfrc_ctrl.sv =====
// Controller state machine of the serial frame receiver.
// Depends on sfrc_pkg for the state type and the command and status structs.
`default_nettype none

module sfrc_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire sfrc_pkg::dp_status_t   dp_status,
    output sfrc_pkg::ctrl_cmd_t         cmd
);

    import sfrc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign accept = s_tvalid && s_tready;

    // Next state and commands.
    always_comb begin
        state_next       = state_reg;
        s_tready         = 1'b0;
        cmd              = '0;
        cmd.emit_status  = STAT_GOOD;
        case (state_reg)
            ST_HUNT: begin
                s_tready = dp_status.out_free;
                if (accept && dp_status.start_match) begin
                    cmd.start  = 1'b1;
                    state_next = ST_RECV;
                end
            end
            ST_RECV: begin
                s_tready = dp_status.out_free;
                if (accept) begin
                    cmd.take = 1'b1;
                    if (dp_status.buf_full) begin
                        cmd.inc_format  = 1'b1;
                        cmd.emit        = 1'b1;
                        cmd.emit_status = STAT_FORMAT;
                        state_next      = ST_HUNT;
                    end else if (dp_status.complete) begin
                        state_next = ST_HUNT;
                        if (dp_status.len_over) begin
                            cmd.inc_format  = 1'b1;
                            cmd.emit        = 1'b1;
                            cmd.emit_status = STAT_FORMAT;
                        end else if (dp_status.hdr_bad || dp_status.sum_bad) begin
                            cmd.inc_checksum = 1'b1;
                            cmd.emit         = 1'b1;
                            cmd.emit_status  = STAT_CHECKSUM;
                        end else begin
                            cmd.inc_good = 1'b1;
                            if (dp_status.len_zero) begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = STAT_GOOD;
                            end else begin
                                cmd.drain_start = 1'b1;
                                state_next      = ST_DRAIN;
                            end
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (dp_status.out_free) begin
                    cmd.drain_load = 1'b1;
                    if (dp_status.drain_last) begin
                        state_next = ST_HUNT;
                    end
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/sfrc_datapath.sv =====
// Datapath of the serial frame receiver: frame fields, running sum, counters,
// configuration registers, payload RAM and output register.
// Depends on sfrc_pkg and sfrc_ram.
`default_nettype none

module sfrc_datapath #(
    parameter int MAX_PAYLOAD = 32,
    parameter int BUFFER_SIZE = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic [sfrc_pkg::BYTE_W-1:0]           s_tdata,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [sfrc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [sfrc_pkg::BYTE_W-1:0]           cfg_data,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [3*sfrc_pkg::BYTE_W+3*sfrc_pkg::COUNT_W-1:0] m_tdata,
    output logic [2:0]                                 m_tuser,
    output logic                                       m_tlast,
    input  wire sfrc_pkg::ctrl_cmd_t                   cmd,
    output sfrc_pkg::dp_status_t                       dp_status
);

    import sfrc_pkg::*;

    localparam int AW = $clog2(MAX_PAYLOAD);
    localparam logic [BYTE_COUNT_W-1:0] BUFFER_LIMIT = BYTE_COUNT_W'(BUFFER_SIZE);
    localparam logic [BYTE_COUNT_W-1:0] STORE_LIMIT  = BYTE_COUNT_W'(MAX_PAYLOAD);
    localparam logic [BYTE_W-1:0]       MAX_LIMIT    = BYTE_W'(MAX_PAYLOAD);

    // Configuration registers.
    logic [BYTE_W-1:0]   header_first_reg;
    logic [BYTE_W-1:0]   header_second_reg;
    logic [MAXLEN_W-1:0] max_payload_reg;

    // Frame state.
    logic [BYTE_COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0]       second_header_reg, second_header_next;
    logic [BYTE_W-1:0]       frame_length_reg, frame_length_next;
    logic [BYTE_W-1:0]       frame_command_reg, frame_command_next;
    logic [BYTE_W-1:0]       running_sum_reg, running_sum_next;
    logic [COUNT_W-1:0]      good_reg, good_next;
    logic [COUNT_W-1:0]      format_reg, format_next;
    logic [COUNT_W-1:0]      checksum_reg, checksum_next;
    logic [AW-1:0]           drain_idx_reg, drain_idx_next;

    // Output register.
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [BYTE_W-1:0]   out_command_reg;
    logic [BYTE_W-1:0]   out_length_reg;
    logic [BYTE_W-1:0]   out_data_reg;
    logic                out_dv_reg;
    logic                out_last_reg;
    logic [COUNT_W-1:0]  out_good_reg;
    logic [COUNT_W-1:0]  out_format_reg;
    logic [COUNT_W-1:0]  out_checksum_reg;

    // Byte folding.
    logic [BYTE_COUNT_W-1:0] cnt_inc;
    logic [BYTE_COUNT_W-1:0] pay_idx;
    logic                    in_payload;
    logic [BYTE_W-1:0]       sh_eff, len_eff, cmd_eff, sum_eff;
    logic [MAXLEN_W-1:0]     limit;

    // Payload RAM.
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [BYTE_W-1:0] ram_rd_data;
    logic [BYTE_W-1:0] drain_next_pos;

    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= RESET_HEADER_FIRST;
            header_second_reg <= RESET_HEADER_SECOND;
            max_payload_reg   <= RESET_MAX_PAYLOAD;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                CFG_HEADER_SECOND: header_second_reg <= cfg_data;
                CFG_MAX_PAYLOAD:   max_payload_reg   <= cfg_data[MAXLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Effect of the incoming byte on the frame fields.
    always_comb begin
        cnt_inc    = byte_count_reg + 7'd1;
        pay_idx    = byte_count_reg - POS_PAYLOAD;
        in_payload = (byte_count_reg >= POS_PAYLOAD)
                     && ({1'b0, pay_idx} < frame_length_reg);
        sh_eff     = (byte_count_reg == POS_SECOND_HEADER) ? s_tdata : second_header_reg;
        len_eff    = (byte_count_reg == POS_LENGTH) ? s_tdata : frame_length_reg;
        cmd_eff    = (byte_count_reg == POS_COMMAND) ? s_tdata : frame_command_reg;
        if ((byte_count_reg == POS_LENGTH) || (byte_count_reg == POS_COMMAND) || in_payload) begin
            sum_eff = running_sum_reg + s_tdata;
        end else begin
            sum_eff = running_sum_reg;
        end
        limit = (BYTE_W'(max_payload_reg) < MAX_LIMIT) ? max_payload_reg
                                                      : MAX_LIMIT[MAXLEN_W-1:0];
    end

    assign ram_wr_en = cmd.take && in_payload && (pay_idx < STORE_LIMIT);

    // Status toward the controller.
    always_comb begin
        dp_status.out_free    = !out_valid_reg || m_tready;
        dp_status.start_match = (s_tdata == header_first_reg);
        dp_status.buf_full    = (cnt_inc >= BUFFER_LIMIT);
        dp_status.complete    = (cnt_inc >= MIN_COMPLETE)
                                && ({2'b00, cnt_inc} >= FRAME_OVERHEAD + {1'b0, len_eff});
        dp_status.len_over    = (len_eff > BYTE_W'(limit));
        dp_status.hdr_bad     = (sh_eff != header_second_reg);
        dp_status.sum_bad     = (sum_eff != s_tdata);
        dp_status.len_zero    = (len_eff == '0);
        dp_status.drain_last  = (drain_next_pos == frame_length_reg);
    end

    assign drain_next_pos = BYTE_W'(drain_idx_reg) + 8'd1;

    // Next values of the frame fields, counters and drain index.
    always_comb begin
        byte_count_next    = byte_count_reg;
        second_header_next = second_header_reg;
        frame_length_next  = frame_length_reg;
        frame_command_next = frame_command_reg;
        running_sum_next   = running_sum_reg;
        drain_idx_next     = drain_idx_reg;
        ram_rd_en          = 1'b0;
        ram_rd_addr        = drain_idx_reg;
        if (cmd.start) begin
            byte_count_next    = POS_SECOND_HEADER;
            second_header_next = '0;
            frame_length_next  = '0;
            frame_command_next = '0;
            running_sum_next   = '0;
        end else if (cmd.take) begin
            byte_count_next    = cnt_inc;
            second_header_next = sh_eff;
            frame_length_next  = len_eff;
            frame_command_next = cmd_eff;
            running_sum_next   = sum_eff;
        end
        good_next     = cmd.inc_good     ? good_reg + 16'd1     : good_reg;
        format_next   = cmd.inc_format   ? format_reg + 16'd1   : format_reg;
        checksum_next = cmd.inc_checksum ? checksum_reg + 16'd1 : checksum_reg;
        if (cmd.drain_start) begin
            ram_rd_en      = 1'b1;
            ram_rd_addr    = '0;
            drain_idx_next = '0;
        end else if (cmd.drain_load && !dp_status.drain_last) begin
            ram_rd_en      = 1'b1;
            ram_rd_addr    = drain_next_pos[AW-1:0];
            drain_idx_next = drain_next_pos[AW-1:0];
        end
    end

    // Frame field and counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            good_reg          <= '0;
            format_reg        <= '0;
            checksum_reg      <= '0;
            byte_count_reg    <= '0;
            second_header_reg <= '0;
            frame_length_reg  <= '0;
            frame_command_reg <= '0;
            running_sum_reg   <= '0;
            drain_idx_reg     <= '0;
        end else begin
            good_reg          <= good_next;
            format_reg        <= format_next;
            checksum_reg      <= checksum_next;
            byte_count_reg    <= byte_count_next;
            second_header_reg <= second_header_next;
            frame_length_reg  <= frame_length_next;
            frame_command_reg <= frame_command_next;
            running_sum_reg   <= running_sum_next;
            drain_idx_reg     <= drain_idx_next;
        end
    end

    // Output register: a status word, or one payload byte of the drain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit || cmd.drain_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            out_status_reg   <= cmd.emit_status;
            out_command_reg  <= cmd_eff;
            out_length_reg   <= len_eff;
            out_data_reg     <= '0;
            out_dv_reg       <= 1'b0;
            out_last_reg     <= 1'b1;
            out_good_reg     <= good_next;
            out_format_reg   <= format_next;
            out_checksum_reg <= checksum_next;
        end else if (cmd.drain_load) begin
            out_status_reg   <= STAT_GOOD;
            out_command_reg  <= frame_command_reg;
            out_length_reg   <= frame_length_reg;
            out_data_reg     <= ram_rd_data;
            out_dv_reg       <= 1'b1;
            out_last_reg     <= dp_status.drain_last;
            out_good_reg     <= good_reg;
            out_format_reg   <= format_reg;
            out_checksum_reg <= checksum_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_dv_reg, out_status_reg};
    assign m_tdata  = {out_checksum_reg, out_format_reg, out_good_reg,
                       out_data_reg, out_length_reg, out_command_reg};

    // Payload store.
    sfrc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (pay_idx[AW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/serial_frame_receiver_checksum.sv =====
// Top level of the serial frame receiver with additive checksum.
// Depends on sfrc_pkg, sfrc_ctrl, sfrc_datapath and sfrc_ram.
//
// The block takes received bytes as words on the s_ channel, hunts for the
// first header byte and collects the frame (second header, length, command,
// payload, checksum). Input words are taken back to back while a frame is
// being collected; they are held off only while the output register is full
// and not being taken. When a good frame with L payload bytes completes, the
// payload is read back from the payload RAM's registered read port one byte
// per cycle while the output register is free, and no input word is taken
// during this drain. Errors and empty frames give one status word at once.
// Word order on the m_ channel is kept under any backpressure.
`default_nettype none

module serial_frame_receiver_checksum #(
    parameter int MAX_PAYLOAD = 32,
    parameter int BUFFER_SIZE = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Received byte.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // Result words.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] command, [15:8] payload_length, [23:16] data_byte,
    // [39:24] good_count, [55:40] format_error_count,
    // [71:56] checksum_error_count
    output logic [71:0]      m_tdata,
    output logic [2:0]       m_tuser,   // [1:0] status, [2] data_valid
    output logic             m_tlast    // last
);

    import sfrc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    // Frame sequencing.
    sfrc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // Frame fields, counters, payload store and output register.
    sfrc_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .dp_status (dp_status)
    );

endmodule

`default_nettype wire
